[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the multimap store.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LLMM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Same-cycle implication.
`define LLMM_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/llmm_pkg.sv]
// Types and constants for the linked-list multimap store.
// No dependencies.
package llmm_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths on the stream ports
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_MATCH    = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

endpackage

[hw/rtl/linked_list_multimap_store.sv]
// Multimap store: linked list of key/value pairs threaded through on-chip memories.
// Depends on llmm_pkg and assert_macros.svh.
// An add passes through S_ADDW and S_PUSH before its result is registered, a full reject through S_PUSH.
// Search and remove follow the links one entry per cycle (one registered read of the
// link memory per hop); a search holds while a second match waits on the output register.
// One request at a time; in_tready is high only while the sequencer is idle, which it
// re-enters as the last result is loaded into the output register.
// Reset (synchronous, rst_n low) clears link-written flags, pointers, count.
`include "assert_macros.svh"

module linked_list_multimap_store
  import llmm_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key [31:0], item_value [63:32]
  input  logic [1:0]             in_tuser,   // operation [1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // found_value [31:0], pair_count [38:32], zero [39]
  output logic [2:0]             out_tuser,  // status [2:0]
  output logic                   out_tlast
);

  localparam int LW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);
  localparam logic [LW-1:0] FULL_COUNT = LW'(ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADDW = 5'b00010,
    S_CHK  = 5'b00100,
    S_REM  = 5'b01000,
    S_PUSH = 5'b10000
  } state_t;

  // Memories. Back links are not kept: removal tracks the predecessor during the walk.
  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] value_mem [ENTRIES];
  logic [LW-1:0]         nl_mem    [ENTRIES];
  logic [ENTRIES-1:0]    nl_set_r;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [LW-1:0]         head_r, head_nxt;
  logic [LW-1:0]         free_r, free_nxt;
  logic [LW-1:0]         count_r, count_nxt;
  logic [LW-1:0]         prev_r, prev_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [VALUE_BITS-1:0] pend_val_r, pend_val_nxt;
  status_t               res_st_r, res_st_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;

  // read port
  logic                  rd_en;
  logic [IW-1:0]         rd_idx, rd_idx_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [LW-1:0]         nl_q;
  logic                  rd_set_q;
  logic [LW-1:0]         link_rd;

  // write ports
  logic                  kv_we;
  logic                  nl_we;
  logic [IW-1:0]         nl_widx;
  logic [LW-1:0]         nl_wdata;

  // output register
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_val_r;
  status_t               out_st_r;
  logic                  out_last_r;
  logic [COUNT_W-1:0]    out_cnt_r;
  logic                  slot_free;
  logic                  push_en;
  logic [VALUE_BITS-1:0] push_val;
  status_t               push_st;
  logic                  push_last;

  logic                  in_acc;
  logic                  key_hit;
  logic                  val_hit;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_val;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_key    = KEY_BITS'(in_tdata[KEY_W-1:0]);
  assign in_val    = VALUE_BITS'(in_tdata[KEY_W +: VALUE_W]);
  assign slot_free = !out_valid_r || out_tready;

  // An entry whose link was never written still holds its reset successor.
  assign link_rd = rd_set_q ? nl_q : (LW'(rd_idx_q) + LW'(1));
  assign key_hit = (key_q == key_r);
  assign val_hit = (val_q == val_r);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    head_nxt     = head_r;
    free_nxt     = free_r;
    count_nxt    = count_r;
    prev_nxt     = prev_r;
    pend_v_nxt   = pend_v_r;
    pend_val_nxt = pend_val_r;
    res_st_nxt   = res_st_r;
    res_val_nxt  = res_val_r;
    rd_en        = 1'b0;
    rd_idx       = head_r[IW-1:0];
    kv_we        = 1'b0;
    nl_we        = 1'b0;
    nl_widx      = free_r[IW-1:0];
    nl_wdata     = head_r;
    push_en      = 1'b0;
    push_val     = res_val_r;
    push_st      = res_st_r;
    push_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = op_t'(in_tuser);
          key_nxt     = in_key;
          val_nxt     = in_val;
          prev_nxt    = NULL_LINK;
          pend_v_nxt  = 1'b0;
          res_val_nxt = '0;
          case (op_t'(in_tuser))
            OP_ADD: begin
              if (free_r == NULL_LINK) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_PUSH;
              end else begin
                rd_en     = 1'b1;
                rd_idx    = free_r[IW-1:0];
                state_nxt = S_ADDW;
              end
            end
            OP_SEARCH, OP_REMOVE: begin
              if (head_r == NULL_LINK) begin
                res_st_nxt = (op_t'(in_tuser) == OP_SEARCH) ? ST_NOMATCH : ST_NOTFOUND;
                state_nxt  = S_PUSH;
              end else begin
                rd_en     = 1'b1;
                rd_idx    = head_r[IW-1:0];
                state_nxt = S_CHK;
              end
            end
            default: ;  // unused code: no result, no change
          endcase
        end
      end

      S_ADDW: begin
        // link_rd is the successor of the free slot taken
        kv_we      = 1'b1;
        nl_we      = 1'b1;
        nl_widx    = free_r[IW-1:0];
        nl_wdata   = head_r;
        head_nxt   = free_r;
        free_nxt   = link_rd;
        count_nxt  = count_r + LW'(1);
        res_st_nxt = ST_ADDED;
        state_nxt  = S_PUSH;
      end

      S_CHK: begin
        if (op_r == OP_SEARCH) begin
          // a second match can only be taken once the held one has gone out
          if (!(key_hit && pend_v_r) || slot_free) begin
            if (key_hit) begin
              if (pend_v_r) begin
                push_en   = 1'b1;
                push_val  = pend_val_r;
                push_st   = ST_MATCH;
                push_last = 1'b0;
              end
              pend_v_nxt   = 1'b1;
              pend_val_nxt = val_q;
            end
            if (link_rd == NULL_LINK) begin
              pend_v_nxt = 1'b0;
              if (key_hit || pend_v_r) begin
                res_st_nxt  = ST_MATCH;
                res_val_nxt = key_hit ? val_q : pend_val_r;
              end else begin
                res_st_nxt  = ST_NOMATCH;
                res_val_nxt = '0;
              end
              state_nxt = S_PUSH;
            end else begin
              rd_en  = 1'b1;
              rd_idx = link_rd[IW-1:0];
            end
          end
        end else begin
          if (key_hit && val_hit) begin
            // unlink from the predecessor; the freed slot is relinked next cycle
            if (prev_r == NULL_LINK) begin
              head_nxt = link_rd;
            end else begin
              nl_we    = 1'b1;
              nl_widx  = prev_r[IW-1:0];
              nl_wdata = link_rd;
            end
            state_nxt = S_REM;
          end else begin
            prev_nxt = LW'(rd_idx_q);
            if (link_rd == NULL_LINK) begin
              res_st_nxt = ST_NOTFOUND;
              state_nxt  = S_PUSH;
            end else begin
              rd_en  = 1'b1;
              rd_idx = link_rd[IW-1:0];
            end
          end
        end
      end

      S_REM: begin
        nl_we      = 1'b1;
        nl_widx    = rd_idx_q;
        nl_wdata   = free_r;
        free_nxt   = LW'(rd_idx_q);
        count_nxt  = (count_r != '0) ? (count_r - LW'(1)) : count_r;
        res_st_nxt = ST_REMOVED;
        state_nxt  = S_PUSH;
      end

      S_PUSH: begin
        if (slot_free) begin
          push_en   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= NULL_LINK;
      free_r   <= '0;
      count_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      free_r   <= free_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    prev_r     <= prev_nxt;
    pend_val_r <= pend_val_nxt;
    res_st_r   <= res_st_nxt;
    res_val_r  <= res_val_nxt;
  end

  // memories: one write per array, one registered read
  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[free_r[IW-1:0]]   <= key_r;
      value_mem[free_r[IW-1:0]] <= val_r;
    end
    if (nl_we) begin
      nl_mem[nl_widx] <= nl_wdata;
    end
    if (rd_en) begin
      key_q    <= key_mem[rd_idx];
      val_q    <= value_mem[rd_idx];
      nl_q     <= nl_mem[rd_idx];
      rd_set_q <= nl_set_r[rd_idx];
      rd_idx_q <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_set_r <= '0;
    end else if (nl_we) begin
      nl_set_r[nl_widx] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      out_val_r  <= push_val;
      out_st_r   <= push_st;
      out_last_r <= push_last;
      out_cnt_r  <= COUNT_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, VALUE_W'(out_val_r)};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  `LLMM_ASSERT(a_free_vs_count, clk, rst_n,
               (free_r == NULL_LINK) == (count_r == FULL_COUNT),
               "free list empty does not agree with pair count")
  `LLMM_ASSERT_IMPLIES(a_idle_no_pend, clk, rst_n, state_r == S_IDLE, !pend_v_r,
                       "held match left over after request")
  `LLMM_ASSERT_IMPLIES(a_add_has_slot, clk, rst_n, state_r == S_ADDW, free_r != NULL_LINK,
                       "add without a free slot")
  `LLMM_ASSERT_IMPLIES(a_push_slot, clk, rst_n, push_en, slot_free,
                       "result pushed over an untaken one")

endmodule
